// ===== rtl/ppa_pkg.sv =====
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared widths, register indexes, reset values and item codes for the
// pulse period averager.
// ----------------------------------------------------------------------------
`default_nettype none

package ppa_pkg;

  // Width of a microsecond timestamp, an interval and the average.
  localparam int TIME_W = 32;

  // Width of the ring length register.
  localparam int RLEN_W = 5;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH = 1'b1;

  // Configuration reset values.
  localparam logic [TIME_W-1:0] MIN_PERIOD_RESET  = 32'd1000;
  localparam logic [RLEN_W-1:0] RING_LENGTH_RESET = 5'd16;

  // Item kind codes.
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

endpackage : ppa_pkg

`default_nettype wire

// ===== rtl/ppa_ifs.sv =====
// ----------------------------------------------------------------------------
// ppa_ifs
// Valid/ready channels of the pulse period averager: the input channel that
// carries edge and read items, and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

// Input channel: one edge or read item per transaction.
interface ppa_in_if
  import ppa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [TIME_W-1:0] edge_time_us;

  modport source (output valid, output func, output edge_time_us, input ready);
  modport sink   (input valid, input func, input edge_time_us, output ready);
endinterface : ppa_in_if

// Result channel: one result per input transaction.
interface ppa_out_if
  import ppa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              period_recorded;
  logic              average_valid;
  logic [TIME_W-1:0] average_period_us;

  modport source (output valid, output period_recorded, output average_valid,
                  output average_period_us, input ready);
  modport sink   (input valid, input period_recorded, input average_valid,
                  input average_period_us, output ready);
endinterface : ppa_out_if

`default_nettype wire

// ===== rtl/ppa_ram.sv =====
// ----------------------------------------------------------------------------
// ppa_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module ppa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : ppa_ram

`default_nettype wire

// ===== rtl/ppa_divider.sv =====
// ----------------------------------------------------------------------------
// ppa_divider
// Restoring bit-serial unsigned divider. One quotient bit is produced per
// cycle; done pulses in the same cycle as the complete quotient appears.
// ----------------------------------------------------------------------------
`default_nettype none

module ppa_divider #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 5,
  localparam int STEP_W = $clog2(DVD_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  qd_r;
  logic [DVS_W:0]    rem_r;
  logic [DVS_W-1:0]  dvs_r;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] diff;
  logic           ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    rem_sh = {rem_r[DVS_W-1:0], qd_r[DVD_W-1]};
    ge     = (rem_sh >= {1'b0, dvs_r});
    diff   = rem_sh - {1'b0, dvs_r};
  end

  // Control state resets; the datapath registers load on start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      qd_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      qd_r  <= {qd_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff : rem_sh;
    end
  end

  assign done     = done_r;
  assign quotient = qd_r;

endmodule : ppa_divider

`default_nettype wire

// ===== rtl/pulse_period_averager_unit.sv =====
// ----------------------------------------------------------------------------
// pulse_period_averager_unit
// Moving average of the intervals between sensor edges, with the interval
// history held in a small RAM.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and returns exactly one result
// for each. An edge transaction computes the interval and, if recorded,
// writes it into the history RAM in the accept cycle; the result is then
// registered in S_EMIT. A read transaction with fresh data sums the filled
// entries in S_SUM through the single RAM read port, divides the sum by the
// count in the bit-serial divider in S_DIV until its done pulse, and then
// registers the result in S_EMIT. A read without fresh data goes straight
// to S_EMIT. A stalled result channel holds the block in S_EMIT until the
// output register is free.
// Each history entry has a valid bit, so an entry never written reads as
// zero and no clearing pass follows reset. A new transaction is accepted
// once the previous result has been moved into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_period_averager_unit
  import ppa_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ppa_in_if.sink                     in_chan,
  ppa_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = TIME_W + CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_EMIT
  } state_t;

  // Registers.
  state_t                 state_r,      state_nxt;
  logic [TIME_W-1:0]      min_period_r, min_period_nxt;
  logic [RLEN_W-1:0]      ring_len_r,   ring_len_nxt;
  logic [TIME_W-1:0]      prev_r,       prev_nxt;
  logic [IDX_W-1:0]       wslot_r,      wslot_nxt;
  logic [CNT_W-1:0]       fill_r,       fill_nxt;
  logic                   fresh_r,      fresh_nxt;
  logic [HISTORY_DEPTH-1:0] ent_vld_r,  ent_vld_nxt;
  logic [CNT_W-1:0]       cnt_r,        cnt_nxt;
  logic [CNT_W-1:0]       rd_idx_r,     rd_idx_nxt;
  logic                   pend_r,       pend_nxt;
  logic                   pend_vld_r,   pend_vld_nxt;
  logic [SUM_W-1:0]       sum_r,        sum_nxt;
  logic                   res_rec_r,    res_rec_nxt;
  logic                   res_avl_r,    res_avl_nxt;
  logic [TIME_W-1:0]      res_avg_r,    res_avg_nxt;
  logic                   out_valid_r,  out_valid_nxt;
  logic                   out_rec_r,    out_rec_nxt;
  logic                   out_avl_r,    out_avl_nxt;
  logic [TIME_W-1:0]      out_avg_r,    out_avg_nxt;

  // Combinational helpers.
  logic [CNT_W-1:0]  act_len;
  logic              in_fire;
  logic [TIME_W-1:0] dt;
  logic              rec_ok;
  logic [CNT_W-1:0]  slot_c;
  logic [CNT_W-1:0]  slot_inc;
  logic [CNT_W-1:0]  fill_clamp;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  logic [TIME_W-1:0] ram_rdata;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_quot;

  // History RAM.
  ppa_ram #(
    .WIDTH (TIME_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (dt),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Bit-serial divider for the mean.
  ppa_divider #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Active ring length: zero counts as one, and it saturates at the depth.
  always_comb begin
    if (ring_len_r == '0) begin
      act_len = CNT_W'(1);
    end else if (32'(ring_len_r) > 32'(HISTORY_DEPTH)) begin
      act_len = CNT_W'(HISTORY_DEPTH);
    end else begin
      act_len = CNT_W'(ring_len_r);
    end
  end

  // Edge arithmetic: wrapping interval, write slot and clamped fill count.
  always_comb begin
    dt         = in_chan.edge_time_us - prev_r;
    rec_ok     = (prev_r != '0) && (dt >= min_period_r);
    slot_c     = (CNT_W'(wslot_r) < act_len) ? CNT_W'(wslot_r) : '0;
    slot_inc   = slot_c + 1'b1;
    fill_clamp = (fill_r > act_len) ? act_len : fill_r;
  end

  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign ram_we        = in_fire && (in_chan.func == FUNC_EDGE) && rec_ok;
  assign ram_waddr     = slot_c[IDX_W-1:0];
  assign ram_raddr     = rd_idx_r[IDX_W-1:0];

  // Next-state logic for the sequencer, the history bookkeeping and the
  // output register.
  always_comb begin
    state_nxt      = state_r;
    min_period_nxt = min_period_r;
    ring_len_nxt   = ring_len_r;
    prev_nxt       = prev_r;
    wslot_nxt      = wslot_r;
    fill_nxt       = fill_r;
    fresh_nxt      = fresh_r;
    ent_vld_nxt    = ent_vld_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    pend_nxt       = 1'b0;
    pend_vld_nxt   = pend_vld_r;
    sum_nxt        = sum_r;
    res_rec_nxt    = res_rec_r;
    res_avl_nxt    = res_avl_r;
    res_avg_nxt    = res_avg_r;
    out_valid_nxt  = out_valid_r;
    out_rec_nxt    = out_rec_r;
    out_avl_nxt    = out_avl_r;
    out_avg_nxt    = out_avg_r;
    div_start      = 1'b0;

    // Configuration writes.
    if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_PERIOD:  min_period_nxt = cfg_wdata[TIME_W-1:0];
        CFG_RING_LENGTH: ring_len_nxt   = cfg_wdata[RLEN_W-1:0];
        default: ;
      endcase
    end

    // The output register drains when the sink takes its transaction.
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_rec_nxt = 1'b0;
          res_avl_nxt = 1'b0;
          res_avg_nxt = '0;
          state_nxt   = S_EMIT;
          if (in_chan.func == FUNC_EDGE) begin
            // Edge: record the interval unless it is bounce or no earlier edge is held.
            if (rec_ok) begin
              ent_vld_nxt[slot_c[IDX_W-1:0]] = 1'b1;
              wslot_nxt   = (slot_inc >= act_len) ? '0 : slot_inc[IDX_W-1:0];
              fill_nxt    = (fill_clamp < act_len) ? fill_clamp + 1'b1 : fill_clamp;
              fresh_nxt   = 1'b1;
              res_rec_nxt = 1'b1;
            end
            prev_nxt = in_chan.edge_time_us;
          end else if (fresh_r) begin
            // Read with fresh data: sum entries 0 to count-1.
            fresh_nxt = 1'b0;
            if (fill_clamp != '0) begin
              cnt_nxt    = fill_clamp;
              rd_idx_nxt = '0;
              sum_nxt    = '0;
              state_nxt  = S_SUM;
            end
          end
        end
      end

      S_SUM: begin
        // Issue one read per cycle; add the data that returns in the next cycle.
        if (pend_r) begin
          sum_nxt = sum_r + (pend_vld_r ? SUM_W'(ram_rdata) : '0);
        end
        if (rd_idx_r != cnt_r) begin
          pend_nxt     = 1'b1;
          pend_vld_nxt = ent_vld_r[rd_idx_r[IDX_W-1:0]];
          rd_idx_nxt   = rd_idx_r + 1'b1;
        end else if (!pend_r) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          res_avl_nxt = 1'b1;
          res_avg_nxt = div_quot[TIME_W-1:0];
          state_nxt   = S_EMIT;
        end
      end

      S_EMIT: begin
        // Move the result into the output register once it is free.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_rec_nxt   = res_rec_r;
          out_avl_nxt   = res_avl_r;
          out_avg_nxt   = res_avg_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      min_period_r <= MIN_PERIOD_RESET;
      ring_len_r   <= RING_LENGTH_RESET;
      prev_r       <= '0;
      wslot_r      <= '0;
      fill_r       <= '0;
      fresh_r      <= 1'b0;
      ent_vld_r    <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      min_period_r <= min_period_nxt;
      ring_len_r   <= ring_len_nxt;
      prev_r       <= prev_nxt;
      wslot_r      <= wslot_nxt;
      fill_r       <= fill_nxt;
      fresh_r      <= fresh_nxt;
      ent_vld_r    <= ent_vld_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pend_vld_r <= pend_vld_nxt;
    sum_r      <= sum_nxt;
    res_rec_r  <= res_rec_nxt;
    res_avl_r  <= res_avl_nxt;
    res_avg_r  <= res_avg_nxt;
    out_rec_r  <= out_rec_nxt;
    out_avl_r  <= out_avl_nxt;
    out_avg_r  <= out_avg_nxt;
  end

  // Result channel.
  assign out_chan.valid             = out_valid_r;
  assign out_chan.period_recorded   = out_rec_r;
  assign out_chan.average_valid     = out_avl_r;
  assign out_chan.average_period_us = out_avg_r;

endmodule : pulse_period_averager_unit

`default_nettype wire
